// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define FFRA_ASSERT(NAME, CLK, RSTN, PROP) \
  NAME: assert property (@(posedge CLK) disable iff (!RSTN) PROP) \
    else $error("%m: check failed");

// Concurrent check that also holds during reset.
`define FFRA_ASSERT_ALWAYS(NAME, CLK, PROP) \
  NAME: assert property (@(posedge CLK) PROP) \
    else $error("%m: check failed");

`endif

// ===== rtl/core/ffra_pkg.sv =====
`timescale 1ns / 1ps

package ffra_pkg;

  // Default geometry of the free table and the index space.
  localparam int MAX_FREE_RANGES = 16;
  localparam int INDEX_WIDTH     = 20;

  // Size register width and its value after reset.
  localparam int TOTAL_WIDTH = 21;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_RESET = 21'd1048576;

  // Depth of the request queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_e;

  // Request classes decided at the front.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SKIP  = 2'd2
  } op_e;

  // Control part of a queued request.
  typedef struct packed {
    logic valid;
    op_e  op;
  } req_ctl_t;

endpackage

// ===== rtl/core/ffra_front.sv =====
`timescale 1ns / 1ps

module ffra_front import ffra_pkg::*; #(
  parameter int INDEX_WIDTH = ffra_pkg::INDEX_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic [INDEX_WIDTH-1:0] start_index_i,
  input  logic [INDEX_WIDTH:0]   length_i,
  output req_ctl_t               req_o,
  input  logic                   req_ready_i,
  output logic [INDEX_WIDTH-1:0] req_start_o,
  output logic [INDEX_WIDTH:0]   req_len_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_e                   q_op_q    [QUEUE_DEPTH];
  logic [INDEX_WIDTH-1:0] q_start_q [QUEUE_DEPTH];
  logic [INDEX_WIDTH:0]   q_len_q   [QUEUE_DEPTH];
  logic [PW-1:0]          wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]          fill_q;
  op_e                    in_op;
  logic                   push, pop;

  // Classify the incoming transaction; a free of length zero changes nothing.
  always_comb begin
    if (!mode_i) begin
      in_op = OP_ALLOC;
    end else if (length_i == '0) begin
      in_op = OP_SKIP;
    end else begin
      in_op = OP_FREE;
    end
  end

  assign in_ready_o = (fill_q != CW'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = req_o.valid && req_ready_i;

  assign req_o.valid = (fill_q != '0);
  assign req_o.op    = q_op_q[rd_ptr_q];
  assign req_start_o = q_start_q[rd_ptr_q];
  assign req_len_o   = q_len_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_op_q[wr_ptr_q]    <= in_op;
      q_start_q[wr_ptr_q] <= start_index_i;
      q_len_q[wr_ptr_q]   <= length_i;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ffra_back.sv =====
`timescale 1ns / 1ps

module ffra_back import ffra_pkg::*; #(
  parameter int MAX_FREE_RANGES = ffra_pkg::MAX_FREE_RANGES,
  parameter int INDEX_WIDTH     = ffra_pkg::INDEX_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [TOTAL_WIDTH-1:0] cfg_wdata_i,
  input  req_ctl_t               req_i,
  output logic                   req_ready_o,
  input  logic [INDEX_WIDTH-1:0] req_start_i,
  input  logic [INDEX_WIDTH:0]   req_len_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [INDEX_WIDTH-1:0] res_start_o,
  output logic [INDEX_WIDTH:0]   res_len_o,
  output status_e                res_status_o
);

  localparam int IW   = INDEX_WIDTH;
  localparam int LW   = INDEX_WIDTH + 1;
  localparam int MAXN = MAX_FREE_RANGES;
  localparam int IDXW = $clog2(MAXN);
  localparam int CNTW = $clog2(MAXN + 1);
  localparam int CLW  = (LW > TOTAL_WIDTH) ? LW : TOTAL_WIDTH;

  // Size of the managed space, limited to the index range.
  function automatic logic [LW-1:0] clamp_span(input logic [TOTAL_WIDTH-1:0] tot);
    logic [CLW-1:0] t;
    logic [CLW-1:0] lim;
    t   = CLW'(tot);
    lim = CLW'(1) << IW;
    if (t > lim) begin
      t = lim;
    end
    return LW'(t);
  endfunction

  localparam logic [LW-1:0] RST_SPAN = clamp_span(TOTAL_RESET);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASCAN,
    S_FMERGE,
    S_FFINISH,
    S_RESULT
  } state_e;

  state_e          state_q;
  logic [IW-1:0]   tab_s_q [MAXN];
  logic [LW-1:0]   tab_l_q [MAXN];
  logic [IW-1:0]   sh_s_q  [MAXN];
  logic [LW-1:0]   sh_l_q  [MAXN];
  logic [CNTW-1:0] cnt_q, r_q, k_q;
  logic [IW-1:0]   st_q, cur_s_q, gs_q;
  logic [LW-1:0]   len_q, cur_l_q, gl_q;
  logic            ins_q, cur_v_q;
  status_e         status_q;

  logic [IW-1:0]   rd_s, e_s;
  logic [LW-1:0]   rd_l, e_l, sat_l;
  logic [LW:0]     sum_l;
  logic [LW-1:0]   span;
  logic            take_new, merge, stream_done, fit, last;

  // Table read at the scan pointer.
  assign rd_s = tab_s_q[r_q[IDXW-1:0]];
  assign rd_l = tab_l_q[r_q[IDXW-1:0]];

  // Allocate scan: first entry long enough.
  assign fit  = (rd_l >= len_q);
  assign last = (CNTW'(r_q + 1'b1) == cnt_q);

  // Free stream: table entries in order with the new range slotted in after
  // every entry whose start is not above it.
  assign stream_done = ins_q && (r_q == cnt_q);
  assign take_new    = !ins_q && ((r_q == cnt_q) || (rd_s > st_q));
  assign e_s         = take_new ? st_q  : rd_s;
  assign e_l         = take_new ? len_q : rd_l;

  // Merge when the running range ends exactly at the next start.
  assign merge = cur_v_q &&
                 (({2'b00, cur_s_q} + {1'b0, cur_l_q}) == {2'b00, e_s});
  assign sum_l = {1'b0, cur_l_q} + {1'b0, e_l};
  assign sat_l = sum_l[LW] ? '1 : sum_l[LW-1:0];

  assign span = clamp_span(cfg_wdata_i);

  assign req_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_RESULT);
  assign res_start_o  = gs_q;
  assign res_len_o    = gl_q;
  assign res_status_o = status_q;

  // Sequencer with the free table and its shadow copy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= (RST_SPAN != '0) ? CNTW'(1) : '0;
      r_q      <= '0;
      k_q      <= '0;
      st_q     <= '0;
      len_q    <= '0;
      cur_s_q  <= '0;
      cur_l_q  <= '0;
      ins_q    <= 1'b0;
      cur_v_q  <= 1'b0;
      gs_q     <= '0;
      gl_q     <= '0;
      status_q <= ST_OK;
      for (int j = 0; j < MAXN; j++) begin
        tab_s_q[j] <= '0;
        tab_l_q[j] <= '0;
        sh_s_q[j]  <= '0;
        sh_l_q[j]  <= '0;
      end
      tab_l_q[0] <= RST_SPAN;
    end else if (cfg_we_i) begin
      // A size write rebuilds the table as one range, or as an empty table for a size of zero.
      tab_s_q[0] <= '0;
      tab_l_q[0] <= span;
      cnt_q      <= (span != '0) ? CNTW'(1) : '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            st_q     <= req_start_i;
            len_q    <= req_len_i;
            r_q      <= '0;
            k_q      <= '0;
            ins_q    <= 1'b0;
            cur_v_q  <= 1'b0;
            gs_q     <= '0;
            gl_q     <= '0;
            status_q <= ST_OK;
            unique case (req_i.op)
              OP_ALLOC: begin
                if (cnt_q == '0) begin
                  status_q <= ST_NO_SPACE;
                  state_q  <= S_RESULT;
                end else begin
                  state_q <= S_ASCAN;
                end
              end
              OP_FREE: state_q <= S_FMERGE;
              default: state_q <= S_RESULT;
            endcase
          end
        end

        S_ASCAN: begin
          if (fit) begin
            gs_q    <= rd_s;
            gl_q    <= len_q;
            state_q <= S_RESULT;
            if (len_q != '0) begin
              if (rd_l == len_q) begin
                // Range used up: close the gap.
                for (int j = 0; j < MAXN - 1; j++) begin
                  if (CNTW'(j) >= r_q) begin
                    tab_s_q[j] <= tab_s_q[j+1];
                    tab_l_q[j] <= tab_l_q[j+1];
                  end
                end
                cnt_q <= cnt_q - 1'b1;
              end else begin
                tab_s_q[r_q[IDXW-1:0]] <= rd_s + len_q[IW-1:0];
                tab_l_q[r_q[IDXW-1:0]] <= rd_l - len_q;
              end
            end
          end else if (last) begin
            status_q <= ST_NO_SPACE;
            state_q  <= S_RESULT;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end

        S_FMERGE: begin
          if (stream_done) begin
            state_q <= S_FFINISH;
          end else begin
            if (take_new) begin
              ins_q <= 1'b1;
            end else begin
              r_q <= r_q + 1'b1;
            end
            if (!cur_v_q) begin
              cur_s_q <= e_s;
              cur_l_q <= e_l;
              cur_v_q <= 1'b1;
            end else if (merge) begin
              cur_l_q <= sat_l;
            end else begin
              // Emit the finished range into the shadow copy; once that is full, it is dropped.
              if (k_q != CNTW'(MAXN)) begin
                sh_s_q[k_q[IDXW-1:0]] <= cur_s_q;
                sh_l_q[k_q[IDXW-1:0]] <= cur_l_q;
                k_q                   <= k_q + 1'b1;
              end
              cur_s_q <= e_s;
              cur_l_q <= e_l;
            end
          end
        end

        S_FFINISH: begin
          state_q <= S_RESULT;
          if (k_q == CNTW'(MAXN)) begin
            status_q <= ST_TABLE_FULL;
          end else begin
            for (int j = 0; j < MAXN; j++) begin
              if (CNTW'(j) == k_q) begin
                tab_s_q[j] <= cur_s_q;
                tab_l_q[j] <= cur_l_q;
              end else begin
                tab_s_q[j] <= sh_s_q[j];
                tab_l_q[j] <= sh_l_q[j];
              end
            end
            cnt_q <= k_q + 1'b1;
          end
        end

        S_RESULT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/first_fit_range_allocator.sv =====
// Allocate: an empty table answers with no space and no scan; otherwise the table scan looks
// at the entries in order until one is long enough or the last has been looked at.
// Free: the merge stream runs over the table plus the new range, then the table is written.
// A free of length zero skips the table. The back end takes one request at a time.
// Reset: asynchronous, active low; the table holds one range [0, 1048576) clamped to the
// index space, and the queue and output register are empty.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module first_fit_range_allocator import ffra_pkg::*; #(
  parameter int MAX_FREE_RANGES = ffra_pkg::MAX_FREE_RANGES,
  parameter int INDEX_WIDTH     = ffra_pkg::INDEX_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [TOTAL_WIDTH-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic [INDEX_WIDTH-1:0] start_index_i,
  input  logic [INDEX_WIDTH:0]   length_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [INDEX_WIDTH-1:0] granted_start_o,
  output logic [INDEX_WIDTH:0]   granted_length_o,
  output logic [1:0]             status_o
);

  req_ctl_t               req;
  logic                   req_ready;
  logic [INDEX_WIDTH-1:0] req_start;
  logic [INDEX_WIDTH:0]   req_len;
  logic                   res_valid, res_ready;
  logic [INDEX_WIDTH-1:0] res_start;
  logic [INDEX_WIDTH:0]   res_len;
  status_e                res_status;

  logic                   out_valid_q;
  logic [INDEX_WIDTH-1:0] out_start_q;
  logic [INDEX_WIDTH:0]   out_len_q;
  status_e                out_status_q;

  logic                   out_fail;
  logic                   out_zero;

  ffra_front #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .start_index_i (start_index_i),
    .length_i      (length_i),
    .req_o         (req),
    .req_ready_i   (req_ready),
    .req_start_o   (req_start),
    .req_len_o     (req_len)
  );

  ffra_back #(
    .MAX_FREE_RANGES (MAX_FREE_RANGES),
    .INDEX_WIDTH     (INDEX_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req),
    .req_ready_o  (req_ready),
    .req_start_i  (req_start),
    .req_len_i    (req_len),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_start_o  (res_start),
    .res_len_o    (res_len),
    .res_status_o (res_status)
  );

  // Output register decouples the result transaction from the engine.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_start_q  <= res_start;
      out_len_q    <= res_len;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_start_o  = out_start_q;
  assign granted_length_o = out_len_q;
  assign status_o         = out_status_q;

  // Terms for the output checks.
  assign out_fail = out_valid_o && (status_o != ST_OK);
  assign out_zero = (granted_start_o == '0) && (granted_length_o == '0);

  // A failed request never grants anything.
  `FFRA_ASSERT(a_fail_grants_zero, clk_i, rst_ni, out_fail |-> out_zero)
  // A result handed over by the engine shows up at the output next cycle.
  `FFRA_ASSERT(a_result_reaches_port, clk_i, rst_ni, (res_valid && res_ready) |=> out_valid_o)
  // An accepted request is queued for the back end next cycle.
  `FFRA_ASSERT(a_request_queued, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> req.valid)

endmodule

// ===== verif/first_fit_range_allocator_tb.sv =====
`timescale 1ns / 1ps

module first_fit_range_allocator_tb;
  import ffra_pkg::*;

  localparam int NRANGES = 16;
  localparam int IW = 20;
  localparam logic [IW:0] LEN_SAT = {(IW + 1){1'b1}};
  localparam longint SPACE = 64'd1 << IW;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = NRANGES + 10;
  localparam int N_RANDOM = 500;

  // Mode codes of a request.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [TOTAL_WIDTH-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = 1'b0;
  logic [IW-1:0] start_index_i = '0;
  logic [IW:0] length_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [IW-1:0] granted_start_o;
  logic [IW:0] granted_length_o;
  logic [1:0] status_o;

  first_fit_range_allocator dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i(mode_i),
    .start_index_i(start_index_i),
    .length_i(length_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .granted_start_o(granted_start_o),
    .granted_length_o(granted_length_o),
    .status_o(status_o)
  );

  typedef struct {
    logic [IW-1:0] start;
    logic [IW:0] len;
    status_e status;
  } grant_t;

  // Free table shadow.
  logic [IW-1:0] free_start [NRANGES];
  logic [IW:0] free_len [NRANGES];
  int free_count;

  grant_t grant_queue [$];
  int errors = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_alloc_ok = 0;
  int n_no_space = 0;
  int n_table_full = 0;
  bit hold_off = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Rebuild the shadow table from a size value, clamped to the index space.
  task automatic load_table(input logic [TOTAL_WIDTH-1:0] size);
    longint span;
    span = (size > SPACE) ? SPACE : size;
    for (int i = 0; i < NRANGES; i++) begin
      free_start[i] = '0;
      free_len[i] = '0;
    end
    free_count = (span == 0) ? 0 : 1;
    free_len[0] = (IW + 1)'(span);
  endtask

  // First-fit allocation against the shadow table.
  function automatic grant_t alloc_first_fit(input logic [IW:0] len);
    grant_t g;
    g = '{start: '0, len: '0, status: ST_NO_SPACE};
    for (int i = 0; i < free_count; i++) begin
      if (free_len[i] >= len) begin
        g = '{start: free_start[i], len: len, status: ST_OK};
        if (len != 0) begin
          free_start[i] = free_start[i] + len[IW-1:0];
          free_len[i] = free_len[i] - len;
          if (free_len[i] == 0) begin
            for (int j = i; j < free_count - 1; j++) begin
              free_start[j] = free_start[j + 1];
              free_len[j] = free_len[j + 1];
            end
            free_count--;
          end
        end
        break;
      end
    end
    return g;
  endfunction

  // Sorted insert and coalescing of a freed range.
  function automatic status_e release_range(input logic [IW-1:0] st, input logic [IW:0] len);
    longint ts [NRANGES + 1];
    longint tl [NRANGES + 1];
    int n;
    int pos;
    int i;
    n = 0;
    if (len == 0) return ST_OK;
    pos = free_count;
    for (i = 0; i < free_count; i++) begin
      if (free_start[i] > st) begin
        pos = i;
        break;
      end
    end
    for (i = 0; i < free_count; i++) begin
      if (i == pos) begin
        ts[n] = st;
        tl[n] = len;
        n++;
      end
      ts[n] = free_start[i];
      tl[n] = free_len[i];
      n++;
    end
    if (pos == free_count) begin
      ts[n] = st;
      tl[n] = len;
      n++;
    end
    i = 0;
    while (i + 1 < n) begin
      if (ts[i] + tl[i] == ts[i + 1]) begin
        tl[i] = (tl[i] + tl[i + 1] > LEN_SAT) ? LEN_SAT : tl[i] + tl[i + 1];
        for (int j = i + 1; j < n - 1; j++) begin
          ts[j] = ts[j + 1];
          tl[j] = tl[j + 1];
        end
        n--;
      end else begin
        i++;
      end
    end
    if (n > NRANGES) return ST_TABLE_FULL;
    for (i = 0; i < n; i++) begin
      free_start[i] = IW'(ts[i]);
      free_len[i] = (IW + 1)'(tl[i]);
    end
    free_count = n;
    return ST_OK;
  endfunction

  // Offer one transaction; the prediction is made at acceptance.
  task automatic send_request(input logic md, input logic [IW-1:0] st, input logic [IW:0] len);
    grant_t g;
    mode_i <= md;
    start_index_i <= st;
    length_i <= len;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (md == MODE_ALLOC) begin
      g = alloc_first_fit(len);
    end else begin
      g = '{start: '0, len: '0, status: release_range(st, len)};
    end
    grant_queue = {grant_queue, g};
    n_accepted++;
  endtask

  task automatic drain_and_settle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [TOTAL_WIDTH-1:0] size);
    drain_and_settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    load_table(size);
  endtask

  // Random length, mostly small, sometimes anything the field allows.
  function automatic logic [IW:0] pick_len();
    case ($urandom_range(0, 9))
      0: return (IW + 1)'($urandom_range(0, (1 << (IW + 1)) - 1));
      1: return '0;
      2: return (IW + 1)'($urandom_range(0, 1 << IW));
      default: return (IW + 1)'($urandom_range(1, 64));
    endcase
  endfunction

  // Receiver: random stalls, with one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_ready_i <= 1'b0;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    grant_t exp_g;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (grant_queue.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_g = grant_queue.pop_front();
        if (granted_start_o !== exp_g.start) begin
          $error("granted_start expected %0d actual %0d", exp_g.start, granted_start_o);
          errors++;
        end
        if (granted_length_o !== exp_g.len) begin
          $error("granted_length expected %0d actual %0d", exp_g.len, granted_length_o);
          errors++;
        end
        if (status_o !== exp_g.status) begin
          $error("status expected %0d actual %0d", exp_g.status, status_o);
          errors++;
        end
        if (exp_g.status == ST_NO_SPACE) n_no_space++;
        if (exp_g.status == ST_TABLE_FULL) n_table_full++;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  typedef struct {
    logic md;
    logic [IW-1:0] st;
    logic [IW:0] len;
    bit typed;
    grant_t want;
  } vec_t;

  vec_t directed [] = '{
    '{MODE_ALLOC, 20'd0, 21'd0, 1'b1, '{20'd0, 21'd0, ST_OK}},
    '{MODE_ALLOC, 20'hFFFFF, 21'd16, 1'b1, '{20'd0, 21'd16, ST_OK}},
    '{MODE_ALLOC, 20'd0, 21'h1FFFFF, 1'b1, '{20'd0, 21'd0, ST_NO_SPACE}},
    '{MODE_FREE, 20'd0, 21'd0, 1'b1, '{20'd0, 21'd0, ST_OK}},
    '{MODE_FREE, 20'd0, 21'd16, 1'b1, '{20'd0, 21'd0, ST_OK}},
    '{MODE_ALLOC, 20'd0, 21'd1048576, 1'b1, '{20'd0, 21'd1048576, ST_OK}},
    '{MODE_ALLOC, 20'd0, 21'd1, 1'b1, '{20'd0, 21'd0, ST_NO_SPACE}},
    '{MODE_ALLOC, 20'd0, 21'd0, 1'b1, '{20'd0, 21'd0, ST_NO_SPACE}},
    '{MODE_FREE, 20'd100, 21'd10, 1'b0, '{20'd0, 21'd0, ST_OK}},
    '{MODE_FREE, 20'd100, 21'd5, 1'b0, '{20'd0, 21'd0, ST_OK}},
    '{MODE_FREE, 20'd90, 21'd10, 1'b0, '{20'd0, 21'd0, ST_OK}},
    '{MODE_FREE, 20'hFFFFF, 21'h1FFFFF, 1'b0, '{20'd0, 21'd0, ST_OK}},
    '{MODE_FREE, 20'h7FFFF, 21'd3, 1'b0, '{20'd0, 21'd0, ST_OK}},
    '{MODE_ALLOC, 20'd0, 21'd7, 1'b0, '{20'd0, 21'd0, ST_OK}},
    '{MODE_ALLOC, 20'd0, 21'd1048575, 1'b0, '{20'd0, 21'd0, ST_OK}}
  };

  // Stimulus.
  initial begin
    grant_t g;
    logic [IW-1:0] st;
    load_table(TOTAL_RESET);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed rows are also checked against the predictor.
    foreach (directed[k]) begin
      send_request(directed[k].md, directed[k].st, directed[k].len);
      if (directed[k].typed) begin
        g = grant_queue[grant_queue.size() - 1];
        if (g.start !== directed[k].want.start) begin
          $error("row %0d granted_start expected %0d actual %0d",
                 k, directed[k].want.start, g.start);
          errors++;
        end
        if (g.len !== directed[k].want.len) begin
          $error("row %0d granted_length expected %0d actual %0d",
                 k, directed[k].want.len, g.len);
          errors++;
        end
        if (g.status !== directed[k].want.status) begin
          $error("row %0d status expected %0d actual %0d",
                 k, directed[k].want.status, g.status);
          errors++;
        end
      end
    end

    // Fill the table with disjoint frees, overflowing it.
    write_size(21'd0);
    for (int k = 0; k < NRANGES + 3; k++) begin
      send_request(MODE_FREE, 20'(k * 8), 21'd4);
    end
    send_request(MODE_FREE, 20'd4, 21'd4);
    send_request(MODE_ALLOC, 20'd0, 21'd100);

    // Long receiver hold-off while the sender keeps offering.
    write_size(21'd1024);
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 12; k++) send_request(MODE_ALLOC, 20'd0, 21'd8);
    join

    // Random phases under several sizes.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_size(21'h1FFFFF);
        1: write_size(21'd4096);
        2: write_size(21'd1);
        3: write_size(TOTAL_WIDTH'($urandom_range(2, 1 << 20)));
        default: write_size(21'd256);
      endcase
      for (int k = 0; k < N_RANDOM / 5; ) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && k < N_RANDOM / 5; b++, k++) begin
          if ($urandom_range(0, 1)) begin
            send_request(MODE_ALLOC, IW'($urandom), pick_len());
          end else begin
            if ($urandom_range(0, 3) == 0) st = IW'($urandom);
            else st = IW'($urandom_range(0, 4095));
            send_request(MODE_FREE, st, pick_len());
          end
        end
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk_i);
        end
      end
    end

    drain_and_settle();
    $display("Requests accepted: %0d, results checked: %0d.", n_accepted, n_results);
    $display("Failed allocates: %0d, table-full frees: %0d.", n_no_space, n_table_full);
    if (errors == 0 && grant_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
